FILE: hw/rtl/dpd_pkg.sv
// Shared types and constants for the dual-side PD drive controller.
// Used by the channel interfaces, the per-side update unit and the top level.
package dpd_pkg;

  // Default position width and gain fraction bits.
  localparam int POS_WIDTH_DEF      = 24;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int POWER_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int LEEWAY_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 16'd0;
  localparam logic [LIMIT_W-1:0]  RAMP_RST       = 15'd2560;
  localparam logic [LIMIT_W-1:0]  MAX_POWER_RST  = 15'd25600;
  localparam logic [LEEWAY_W-1:0] LEEWAY_RST     = 16'd5;
  localparam logic [COUNT_W-1:0]  TIMEOUT_RST    = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LEFT  = 3'd0,
    CFG_TARGET_RIGHT = 3'd1,
    CFG_PROP_GAIN    = 3'd2,
    CFG_DERIV_GAIN   = 3'd3,
    CFG_RAMP_LIMIT   = 3'd4,
    CFG_MAX_POWER    = 3'd5,
    CFG_LEEWAY       = 3'd6,
    CFG_TIMEOUT      = 3'd7
  } cfg_idx_e;

  // Controller settings handed to each side's update unit.
  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] ramp_limit;
    logic [LIMIT_W-1:0] max_power;
  } gains_t;

endpackage

FILE: hw/rtl/dpd_in_if.sv
// Input channel: start flag and one encoder position per side.
// Depends on dpd_pkg for the default position width.
interface dpd_in_if #(
  parameter int PosWidth = dpd_pkg::POS_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       start_req;
  logic signed [PosWidth-1:0] measured_left;
  logic signed [PosWidth-1:0] measured_right;

  modport source (output valid, output start_req, output measured_left,
                  output measured_right, input ready);
  modport sink   (input valid, input start_req, input measured_left,
                  input measured_right, output ready);
endinterface

FILE: hw/rtl/dpd_out_if.sv
// Output channel: drive power per side plus done and timeout flags.
// Depends on dpd_pkg for the power width.
interface dpd_out_if;
  import dpd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] power_left;
  logic signed [POWER_W-1:0] power_right;
  logic                      done_res;
  logic                      timed_out;

  modport source (output valid, output power_left, output power_right,
                  output done_res, output timed_out, input ready);
  modport sink   (input valid, input power_left, input power_right,
                  input done_res, input timed_out, output ready);
endinterface

FILE: hw/rtl/dpd_chan.sv
// One side of the PD controller: target power from error and its change,
// then a slew-limited and clamped drive update. Depends on dpd_pkg.
module dpd_chan #(
  parameter int PosWidth     = dpd_pkg::POS_WIDTH_DEF,
  parameter int GainFracBits = dpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic signed [PosWidth-1:0]         err_i,
  input  logic signed [PosWidth-1:0]         prev_err_i,
  input  logic signed [dpd_pkg::POWER_W-1:0] drive_i,
  input  dpd_pkg::gains_t                    gains_i,
  output logic signed [dpd_pkg::POWER_W-1:0] drive_o
);
  import dpd_pkg::*;

  localparam int DiffW = PosWidth + 1;
  localparam int PropW = PosWidth + GAIN_W + 1;
  localparam int DerW  = DiffW + GAIN_W + 1;
  localparam int SumW  = DerW + 1;
  localparam int ShL   = (GainFracBits < 8) ? (8 - GainFracBits) : 0;
  localparam int ShR   = (GainFracBits >= 8) ? (GainFracBits - 8) : 0;
  localparam int TpW   = SumW + ShL;
  localparam int GapW  = TpW + 1;

  logic signed [DiffW-1:0]    diff;
  logic signed [GAIN_W:0]     kp_s;
  logic signed [GAIN_W:0]     kd_s;
  logic signed [PropW-1:0]    prod_p;
  logic signed [DerW-1:0]     prod_d;
  logic signed [SumW-1:0]     pd_sum;
  logic signed [TpW-1:0]      tp;
  logic signed [GapW-1:0]     gap;
  logic signed [GapW-1:0]     ramp_s;
  logic signed [POWER_W-1:0]  delta;
  logic signed [POWER_W:0]    moved;
  logic signed [POWER_W:0]    max_s;

  // Error change and the two gain products.
  assign diff   = DiffW'(err_i) - DiffW'(prev_err_i);
  assign kp_s   = (GAIN_W + 1)'({1'b0, gains_i.prop_gain});
  assign kd_s   = (GAIN_W + 1)'({1'b0, gains_i.deriv_gain});
  assign prod_p = err_i * kp_s;
  assign prod_d = diff * kd_s;
  assign pd_sum = SumW'(prod_p) + SumW'(prod_d);

  // Rescale to Q8.8; the right shift floors toward minus infinity.
  assign tp = (TpW'(pd_sum) <<< ShL) >>> ShR;

  // Step toward the target power by at most the ramp limit.
  assign gap    = GapW'(tp) - GapW'(drive_i);
  assign ramp_s = GapW'({1'b0, gains_i.ramp_limit});

  always_comb begin
    if (gap > ramp_s) begin
      delta = POWER_W'(ramp_s);
    end else if (gap < -ramp_s) begin
      delta = POWER_W'(-ramp_s);
    end else begin
      delta = POWER_W'(gap);
    end
  end

  // Clamp the moved drive to the power limit.
  assign moved = (POWER_W + 1)'(drive_i) + (POWER_W + 1)'(delta);
  assign max_s = (POWER_W + 1)'({1'b0, gains_i.max_power});

  always_comb begin
    if (moved > max_s) begin
      drive_o = POWER_W'(max_s);
    end else if (moved < -max_s) begin
      drive_o = POWER_W'(-max_s);
    end else begin
      drive_o = POWER_W'(moved);
    end
  end

endmodule

FILE: hw/rtl/dual_pd_drive_with_slew_limit.sv
// Channel  | Direction | Payload
// in_if    | sink      | start_req, measured_left, measured_right
// out_if   | source    | power_left, power_right, done_res, timed_out
// cfg      | write     | cfg_we_i, cfg_idx_i, cfg_data_i (no read-back)
//
// One result beat per input beat; a new input beat can be taken every cycle unless
// a stalled output has backed up into a full input register. The input register holds
// the saturated errors, then the PD update feeds the result register; the drive state loop closes there.
// Reset clears the controller state and loads the register defaults.
// A stalled output holds its beat; the input register still fills behind it.
// Depends on dpd_pkg, dpd_in_if, dpd_out_if and dpd_chan.
module dual_pd_drive_with_slew_limit #(
  parameter int PosWidth     = dpd_pkg::POS_WIDTH_DEF,
  parameter int GainFracBits = dpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  dpd_pkg::cfg_idx_e                         cfg_idx_i,
  input  logic [((PosWidth > 16) ? PosWidth : 16)-1:0] cfg_data_i,
  dpd_in_if.sink                                    in_if,
  dpd_out_if.source                                 out_if
);
  import dpd_pkg::*;

  localparam int ErrW = PosWidth + 1;
  localparam int MagW = (PosWidth > LEEWAY_W) ? PosWidth : LEEWAY_W;
  localparam logic signed [PosWidth-1:0] ErrMax = {1'b0, {(PosWidth-1){1'b1}}};
  localparam logic signed [PosWidth-1:0] ErrMin = {1'b1, {(PosWidth-1){1'b0}}};

  // Configuration registers.
  logic signed [PosWidth-1:0] target_l_q, target_r_q;
  gains_t                     gains_q;
  logic [LEEWAY_W-1:0]        leeway_q;
  logic [COUNT_W-1:0]         timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_l_q           <= '0;
      target_r_q           <= '0;
      gains_q.prop_gain    <= PROP_GAIN_RST;
      gains_q.deriv_gain   <= DERIV_GAIN_RST;
      gains_q.ramp_limit   <= RAMP_RST;
      gains_q.max_power    <= MAX_POWER_RST;
      leeway_q             <= LEEWAY_RST;
      timeout_q            <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_LEFT:  target_l_q         <= cfg_data_i[PosWidth-1:0];
        CFG_TARGET_RIGHT: target_r_q         <= cfg_data_i[PosWidth-1:0];
        CFG_PROP_GAIN:    gains_q.prop_gain  <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN:   gains_q.deriv_gain <= cfg_data_i[GAIN_W-1:0];
        CFG_RAMP_LIMIT:   gains_q.ramp_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_MAX_POWER:    gains_q.max_power  <= cfg_data_i[LIMIT_W-1:0];
        CFG_LEEWAY:       leeway_q           <= cfg_data_i[LEEWAY_W-1:0];
        CFG_TIMEOUT:      timeout_q          <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register advances when empty or being taken.
  logic a_valid_q, out_valid_q;
  logic advance, fire_b;

  assign advance     = !out_valid_q || out_if.ready;
  assign fire_b      = a_valid_q && advance;
  assign in_if.ready = !a_valid_q || advance;

  // Saturated position errors, computed on the incoming beat.
  logic signed [ErrW-1:0]     raw_l, raw_r;
  logic signed [PosWidth-1:0] err_l_d, err_r_d;

  assign raw_l = ErrW'(target_l_q) - ErrW'(in_if.measured_left);
  assign raw_r = ErrW'(target_r_q) - ErrW'(in_if.measured_right);

  always_comb begin
    if (raw_l > ErrW'(ErrMax))      err_l_d = ErrMax;
    else if (raw_l < ErrW'(ErrMin)) err_l_d = ErrMin;
    else                            err_l_d = PosWidth'(raw_l);
    if (raw_r > ErrW'(ErrMax))      err_r_d = ErrMax;
    else if (raw_r < ErrW'(ErrMin)) err_r_d = ErrMin;
    else                            err_r_d = PosWidth'(raw_r);
  end

  // Input register.
  logic                       a_start_q;
  logic signed [PosWidth-1:0] a_err_l_q, a_err_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      a_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      a_start_q <= in_if.start_req;
      a_err_l_q <= err_l_d;
      a_err_r_q <= err_r_d;
    end
  end

  // Controller state.
  logic signed [PosWidth-1:0] prev_l_q, prev_r_q, prev_l_d, prev_r_d;
  logic signed [POWER_W-1:0]  drive_l_q, drive_r_q, drive_l_d, drive_r_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic                       finished_q, finished_d, tohit_q, tohit_d;

  // A start beat clears the history before the step is evaluated.
  logic signed [PosWidth-1:0] prev_l_eff, prev_r_eff;
  logic signed [POWER_W-1:0]  drive_l_eff, drive_r_eff;
  logic [COUNT_W-1:0]         count_eff;
  logic                       fin_eff, toh_eff;

  assign prev_l_eff  = a_start_q ? a_err_l_q : prev_l_q;
  assign prev_r_eff  = a_start_q ? a_err_r_q : prev_r_q;
  assign drive_l_eff = a_start_q ? '0 : drive_l_q;
  assign drive_r_eff = a_start_q ? '0 : drive_r_q;
  assign count_eff   = a_start_q ? '0 : count_q;
  assign fin_eff     = a_start_q ? 1'b0 : finished_q;
  assign toh_eff     = a_start_q ? 1'b0 : tohit_q;

  // Arrival and timeout checks.
  logic [PosWidth-1:0] mag_l, mag_r;
  logic                arrived, expired, run;

  assign mag_l   = a_err_l_q[PosWidth-1] ? (~a_err_l_q + 1'b1) : a_err_l_q;
  assign mag_r   = a_err_r_q[PosWidth-1] ? (~a_err_r_q + 1'b1) : a_err_r_q;
  assign arrived = (MagW'(mag_l) <= MagW'(leeway_q)) && (MagW'(mag_r) <= MagW'(leeway_q));
  assign expired = count_eff >= timeout_q;
  assign run     = !fin_eff && !arrived && !expired;

  // Per-side drive updates.
  logic signed [POWER_W-1:0] next_l, next_r;

  dpd_chan #(
    .PosWidth     (PosWidth),
    .GainFracBits (GainFracBits)
  ) u_chan_l (
    .err_i      (a_err_l_q),
    .prev_err_i (prev_l_eff),
    .drive_i    (drive_l_eff),
    .gains_i    (gains_q),
    .drive_o    (next_l)
  );

  dpd_chan #(
    .PosWidth     (PosWidth),
    .GainFracBits (GainFracBits)
  ) u_chan_r (
    .err_i      (a_err_r_q),
    .prev_err_i (prev_r_eff),
    .drive_i    (drive_r_eff),
    .gains_i    (gains_q),
    .drive_o    (next_r)
  );

  // Next state; a finished move holds its power.
  assign finished_d = fin_eff || arrived || expired;
  assign tohit_d    = toh_eff || (!fin_eff && !arrived && expired);
  assign drive_l_d  = run ? next_l : drive_l_eff;
  assign drive_r_d  = run ? next_r : drive_r_eff;
  assign prev_l_d   = run ? a_err_l_q : prev_l_eff;
  assign prev_r_d   = run ? a_err_r_q : prev_r_eff;
  assign count_d    = (run && (count_eff != {COUNT_W{1'b1}})) ? count_eff + 1'b1 : count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q   <= '0;
      prev_r_q   <= '0;
      drive_l_q  <= '0;
      drive_r_q  <= '0;
      count_q    <= '0;
      finished_q <= 1'b0;
      tohit_q    <= 1'b0;
    end else if (fire_b) begin
      prev_l_q   <= prev_l_d;
      prev_r_q   <= prev_r_d;
      drive_l_q  <= drive_l_d;
      drive_r_q  <= drive_r_d;
      count_q    <= count_d;
      finished_q <= finished_d;
      tohit_q    <= tohit_d;
    end
  end

  // Result register.
  logic signed [POWER_W-1:0] out_pl_q, out_pr_q;
  logic                      out_done_q, out_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_b) begin
      out_pl_q   <= drive_l_d;
      out_pr_q   <= drive_r_d;
      out_done_q <= finished_d;
      out_to_q   <= tohit_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.power_left  = out_pl_q;
  assign out_if.power_right = out_pr_q;
  assign out_if.done_res    = out_done_q;
  assign out_if.timed_out   = out_to_q;

endmodule

FILE: test/dpd_power_checker.sv
// Checker for the dual-side PD drive: predicts every result beat and compares it.
// Watches the config port and both channels; depends on dpd_pkg, dpd_in_if, dpd_out_if.
module dpd_power_checker
  import dpd_pkg::*;
#(
  parameter int PosWidth     = POS_WIDTH_DEF,
  parameter int GainFracBits = GAIN_FRAC_BITS_DEF,
  parameter int CfgWidth     = (PosWidth > 16) ? PosWidth : 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  dpd_in_if                   in_ch,
  dpd_out_if                  out_ch,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  done_beats_o,
  output int                  timed_out_beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_HI     = (longint'(1) <<< (PosWidth - 1)) - 1;
  localparam int     SHIFT_DOWN = (GainFracBits >= 8) ? GainFracBits - 8 : 0;
  localparam int     SHIFT_UP   = (GainFracBits < 8) ? 8 - GainFracBits : 0;

  typedef struct packed {
    logic signed [POWER_W-1:0] power_left;
    logic signed [POWER_W-1:0] power_right;
    logic                      done_res;
    logic                      timed_out;
  } power_beat_t;

  // Expected result beats, oldest first.
  power_beat_t expected_q[$];

  // Shadow copy of the configuration registers.
  logic signed [PosWidth-1:0] tgt_left, tgt_right;
  logic [GAIN_W-1:0]          kp, kd;
  logic [LIMIT_W-1:0]         ramp, cap;
  logic [LEEWAY_W-1:0]        leeway;
  logic [COUNT_W-1:0]         timeout;

  // Shadow copy of the controller state.
  logic signed [PosWidth-1:0] prev_err_l, prev_err_r;
  logic signed [POWER_W-1:0]  drive_l, drive_r;
  logic [COUNT_W-1:0]         steps;
  logic                       finished, timeout_latched;

  int mismatches = 0;
  int checked = 0;
  int done_beats = 0;
  int timed_out_beats = 0;

  assign fail_count_o      = mismatches;
  assign checked_o         = checked;
  assign done_beats_o      = done_beats;
  assign timed_out_beats_o = timed_out_beats;

  // Target minus position, saturated to the signed position range.
  function automatic logic signed [PosWidth-1:0] saturated_error(
    logic signed [PosWidth-1:0] target, logic signed [PosWidth-1:0] pos);
    longint diff;
    diff = longint'(target) - longint'(pos);
    if (diff > POS_HI) begin
      diff = POS_HI;
    end else if (diff < -POS_HI - 1) begin
      diff = -POS_HI - 1;
    end
    return diff[PosWidth-1:0];
  endfunction

  function automatic longint clamp_sym(longint v, longint limit);
    if (v > limit) return limit;
    if (v < -limit) return -limit;
    return v;
  endfunction

  function automatic bit within_leeway(logic signed [PosWidth-1:0] err);
    longint m;
    m = (err < 0) ? -longint'(err) : longint'(err);
    return m <= longint'(leeway);
  endfunction

  // One PD update: the target power, reached by at most the ramp, then capped.
  function automatic logic signed [POWER_W-1:0] next_drive(
    logic signed [POWER_W-1:0] drive, logic signed [PosWidth-1:0] err,
    logic signed [PosWidth-1:0] prev);
    longint pd_sum, wanted, moved;
    pd_sum = longint'(err) * longint'(kp)
           + (longint'(err) - longint'(prev)) * longint'(kd);
    wanted = (pd_sum >>> SHIFT_DOWN) <<< SHIFT_UP;
    moved  = longint'(drive) + clamp_sym(wanted - longint'(drive), longint'(ramp));
    moved  = clamp_sym(moved, longint'(cap));
    return moved[POWER_W-1:0];
  endfunction

  task automatic flag(string field, longint want, longint got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    power_beat_t                want, seen;
    logic signed [PosWidth-1:0] err_l, err_r;
    if (!rst_ni) begin
      tgt_left        = '0;
      tgt_right       = '0;
      kp              = PROP_GAIN_RST;
      kd              = DERIV_GAIN_RST;
      ramp            = RAMP_RST;
      cap             = MAX_POWER_RST;
      leeway          = LEEWAY_RST;
      timeout         = TIMEOUT_RST;
      prev_err_l      = '0;
      prev_err_r      = '0;
      drive_l         = '0;
      drive_r         = '0;
      steps           = '0;
      finished        = 1'b0;
      timeout_latched = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // Compare a departing result beat with the oldest expectation.
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.power_left, out_ch.power_right, out_ch.done_res, out_ch.timed_out};
        if (expected_q.size() == 0) begin
          flag("unexpected result beat, power_left", 0, seen.power_left);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (seen.done_res) done_beats++;
          if (seen.timed_out) timed_out_beats++;
          if (seen.power_left !== want.power_left) begin
            flag("power_left", want.power_left, seen.power_left);
          end
          if (seen.power_right !== want.power_right) begin
            flag("power_right", want.power_right, seen.power_right);
          end
          if (seen.done_res !== want.done_res) begin
            flag("done_res", want.done_res, seen.done_res);
          end
          if (seen.timed_out !== want.timed_out) begin
            flag("timed_out", want.timed_out, seen.timed_out);
          end
        end
      end

      // Advance the controller on an accepted sample beat.
      if (in_ch.valid && in_ch.ready) begin
        err_l = saturated_error(tgt_left, in_ch.measured_left);
        err_r = saturated_error(tgt_right, in_ch.measured_right);
        if (in_ch.start_req) begin
          prev_err_l      = err_l;
          prev_err_r      = err_r;
          drive_l         = '0;
          drive_r         = '0;
          steps           = '0;
          finished        = 1'b0;
          timeout_latched = 1'b0;
        end
        if (!finished) begin
          if (within_leeway(err_l) && within_leeway(err_r)) begin
            finished = 1'b1;
          end else if (steps >= timeout) begin
            finished        = 1'b1;
            timeout_latched = 1'b1;
          end else begin
            drive_l    = next_drive(drive_l, err_l, prev_err_l);
            drive_r    = next_drive(drive_r, err_r, prev_err_r);
            prev_err_l = err_l;
            prev_err_r = err_r;
            if (steps != '1) steps++;
          end
        end
        want = '{drive_l, drive_r, finished, timeout_latched};
        expected_q.push_back(want);
      end

      // Register writes take effect for the following beats.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET_LEFT:  tgt_left  = cfg_data_i[PosWidth-1:0];
          CFG_TARGET_RIGHT: tgt_right = cfg_data_i[PosWidth-1:0];
          CFG_PROP_GAIN:    kp        = cfg_data_i[GAIN_W-1:0];
          CFG_DERIV_GAIN:   kd        = cfg_data_i[GAIN_W-1:0];
          CFG_RAMP_LIMIT:   ramp      = cfg_data_i[LIMIT_W-1:0];
          CFG_MAX_POWER:    cap       = cfg_data_i[LIMIT_W-1:0];
          CFG_LEEWAY:       leeway    = cfg_data_i[LEEWAY_W-1:0];
          CFG_TIMEOUT:      timeout   = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: test/tb_dual_pd_drive_with_slew_limit.sv
// Testbench top for the dual-side PD drive: clock, reset, register settings and samples.
// Depends on dpd_pkg, dpd_in_if, dpd_out_if, the block itself and dpd_power_checker.
module tb_dual_pd_drive_with_slew_limit;
  timeunit 1ns;
  timeprecision 1ps;
  import dpd_pkg::*;

  localparam int     POS_W          = POS_WIDTH_DEF;
  localparam int     CFG_W          = (POS_W > 16) ? POS_W : 16;
  localparam longint POS_MAX        = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN        = -POS_MAX - 1;
  localparam int     RANDOM_SAMPLES = 1250;
  localparam int     QUIET_TAIL     = 150;
  localparam int     LONG_HOLD      = 120;
  localparam int     SETTLE         = 6;
  localparam longint CYCLE_LIMIT    = 500000;

  typedef struct {
    logic signed [POS_W-1:0] tgt_l;
    logic signed [POS_W-1:0] tgt_r;
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       kd;
    logic [LIMIT_W-1:0]      ramp;
    logic [LIMIT_W-1:0]      maxp;
    logic [LEEWAY_W-1:0]     leeway;
    logic [COUNT_W-1:0]      timeout;
  } drive_settings_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  dpd_in_if #(.PosWidth(POS_W)) sample_ch ();
  dpd_out_if                    power_ch ();

  int     fail_count, pending, checked, done_beats, timed_out_beats;
  int     samples_sent = 0;
  int     random_start = 0;
  int     phases_run = 0;
  int     moves_run = 0;
  int     long_holds = 0;
  bit     in_random = 1'b0;
  bit     quiet = 1'b0;
  bit     calm = 1'b0;
  bit     hold_request = 1'b0;
  longint cycles = 0;

  dual_pd_drive_with_slew_limit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (sample_ch),
    .out_if     (power_ch)
  );

  dpd_power_checker #(.PosWidth(POS_W)) power_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_ch             (sample_ch),
    .out_ch            (power_ch),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .done_beats_o      (done_beats),
    .timed_out_beats_o (timed_out_beats)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_dual_pd_drive_with_slew_limit failed");
      $finish;
    end
  end

  function automatic logic signed [POS_W-1:0] clip_pos(longint v);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic longint rand_pos();
    logic signed [POS_W-1:0] r;
    r = POS_W'($urandom);
    return longint'(r);
  endfunction

  function automatic longint pick_target();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return longint'($urandom_range(0, 10000)) - 5000;
      2: return rand_pos();
      default: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(0, 512);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_power();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 25600;
      2: return $urandom_range(1, 300);
      default: return $urandom_range(1, 25599);
    endcase
  endfunction

  // Starting error of a move, from close in to well past the position range.
  function automatic longint pick_error();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 100)) - 50;
      1: return longint'($urandom_range(0, 10000)) - 5000;
      2: return rand_pos();
      default: return 2 * rand_pos();
    endcase
  endfunction

  // Plant stand-in: the error shrinks by a random share with a little jitter, and now and then snaps close to zero.
  function automatic longint next_error(longint e);
    longint n;
    n = e - (e * longint'($urandom_range(1, 7))) / 8 + longint'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 15) == 0) n = longint'($urandom_range(0, 6)) - 3;
    return n;
  endfunction

  function automatic drive_settings_t make_settings(longint tl, longint tr, int kp, int kd,
                                                    int ramp, int maxp, int leeway,
                                                    int timeout);
    drive_settings_t s;
    s.tgt_l   = clip_pos(tl);
    s.tgt_r   = clip_pos(tr);
    s.kp      = GAIN_W'(kp);
    s.kd      = GAIN_W'(kd);
    s.ramp    = LIMIT_W'(ramp);
    s.maxp    = LIMIT_W'(maxp);
    s.leeway  = LEEWAY_W'(leeway);
    s.timeout = COUNT_W'(timeout);
    return s;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input drive_settings_t s);
    write_reg(CFG_TARGET_LEFT, CFG_W'(s.tgt_l));
    write_reg(CFG_TARGET_RIGHT, CFG_W'(s.tgt_r));
    write_reg(CFG_PROP_GAIN, CFG_W'(s.kp));
    write_reg(CFG_DERIV_GAIN, CFG_W'(s.kd));
    write_reg(CFG_RAMP_LIMIT, CFG_W'(s.ramp));
    write_reg(CFG_MAX_POWER, CFG_W'(s.maxp));
    write_reg(CFG_LEEWAY, CFG_W'(s.leeway));
    write_reg(CFG_TIMEOUT, CFG_W'(s.timeout));
    cfg_we <= 1'b0;
  endtask

  // Offer one sample beat, maybe after an idle burst, and wait for its acceptance.
  task automatic send_sample(input logic start, input longint left_pos, input longint right_pos);
    quiet = in_random && (samples_sent - random_start >= RANDOM_SAMPLES - QUIET_TAIL);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.start_req      <= start;
    sample_ch.measured_left  <= clip_pos(left_pos);
    sample_ch.measured_right <= clip_pos(right_pos);
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  // Stop offering and wait until every result beat has come back.
  task automatic settle_block();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One move: in most moves a start beat, and a converging trajectory, with stray beats mixed in.
  task automatic run_move(input drive_settings_t s);
    longint err_l, err_r;
    int     len;
    bit     fresh;
    err_l = pick_error();
    err_r = pick_error();
    fresh = ($urandom_range(0, 7) != 0);
    len   = $urandom_range(3, 40);
    moves_run++;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_sample($urandom_range(0, 5) == 0, rand_pos(), rand_pos());
      end else begin
        send_sample(k == 0 && fresh, longint'(s.tgt_l) - err_l, longint'(s.tgt_r) - err_r);
      end
      err_l = next_error(err_l);
      err_r = next_error(err_r);
    end
  endtask

  // Output side: random ready bursts, one long hold on request, none at the tail.
  initial begin : sink_pacing
    power_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        power_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_holds++;
      end else if (quiet || calm || $urandom_range(0, 3) != 0) begin
        power_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        power_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    drive_settings_t s;
    bit              pressed;
    int              moves;
    pressed                  = 1'b0;
    rst_ni                   <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_idx                  <= CFG_TARGET_LEFT;
    cfg_data                 <= '0;
    sample_ch.valid          <= 1'b0;
    sample_ch.start_req      <= 1'b0;
    sample_ch.measured_left  <= '0;
    sample_ch.measured_right <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings and no start: runs from zero history, then arrives and holds.
    send_sample(1'b0, 1000, -1000);
    send_sample(1'b0, 900, -900);
    send_sample(1'b0, 3, -2);
    send_sample(1'b0, 500, 500);

    // Extreme targets and gains: saturated errors, then arrival on the timeout step.
    settle_block();
    load_settings(make_settings(POS_MAX, POS_MIN, 65535, 65535, 25600, 25600, 0, 3));
    send_sample(1'b1, POS_MIN, POS_MAX);
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, -5, 5);
    send_sample(1'b0, POS_MAX, POS_MIN);
    send_sample(1'b0, 7, 7);

    // Zero timeout, zero ramp and zero power cap.
    settle_block();
    load_settings(make_settings(0, 0, 256, 0, 0, 0, 5, 0));
    send_sample(1'b1, 1000, -1000);
    send_sample(1'b0, 20, 20);
    send_sample(1'b1, 2, -3);
    send_sample(1'b1, 40, -40);

    // Derivative only, running into a short timeout.
    settle_block();
    load_settings(make_settings(-100, 100, 0, 512, 25600, 100, 2, 2));
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, -50, 50);
    send_sample(1'b0, -90, 90);

    // An ordinary move that arrives.
    settle_block();
    load_settings(make_settings(1000, -1000, 300, 40, 700, 25600, 3, 65535));
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, 400, -400);
    send_sample(1'b0, 800, -800);
    send_sample(1'b0, 999, -1001);

    // Random phases: fresh settings, then several moves under them.
    in_random    = 1'b1;
    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_SAMPLES) begin
      settle_block();
      s.tgt_l = clip_pos(pick_target());
      s.tgt_r = clip_pos(pick_target());
      s.kp    = GAIN_W'(pick_gain());
      s.kd    = GAIN_W'(pick_gain());
      s.ramp  = LIMIT_W'(pick_power());
      s.maxp  = LIMIT_W'(pick_power());
      case ($urandom_range(0, 7))
        0: s.leeway = '0;
        1: s.leeway = '1;
        2: s.leeway = LEEWAY_W'($urandom_range(0, 65535));
        default: s.leeway = LEEWAY_W'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 7))
        0: s.timeout = '0;
        1: s.timeout = '1;
        2: s.timeout = COUNT_W'(1000);
        default: s.timeout = COUNT_W'($urandom_range(1, 40));
      endcase
      load_settings(s);
      calm = ($urandom_range(0, 3) == 0);
      phases_run++;
      if (!pressed && samples_sent - random_start > 300) begin
        pressed      = 1'b1;
        hold_request = 1'b1;
      end
      moves = $urandom_range(2, 5);
      for (int m = 0; m < moves && samples_sent - random_start < RANDOM_SAMPLES; m++) begin
        run_move(s);
      end
    end

    settle_block();
    $display("Sent %0d samples over %0d random setting phases and %0d random moves;",
             samples_sent, phases_run, moves_run);
    $display("%0d result beats checked, %0d done, %0d by timeout, %0d long output holds.",
             checked, done_beats, timed_out_beats, long_holds);
    if (fail_count == 0) begin
      $display("tb_dual_pd_drive_with_slew_limit passed");
    end else begin
      $display("tb_dual_pd_drive_with_slew_limit failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_in_if.sv
hw/rtl/dpd_out_if.sv
hw/rtl/dpd_chan.sv
hw/rtl/dual_pd_drive_with_slew_limit.sv
test/dpd_power_checker.sv
test/tb_dual_pd_drive_with_slew_limit.sv
